// File: sv/ppts_pkg.sv
// Package for the priority periodic task scheduler.
// Holds the request/response types, operation, status and task-state codes.
// No dependencies.
package ppts_pkg;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_SCHEDULE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_FULL      = 3'd2,
        ST_CLAMPED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TS_DORMANT = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_WAITING = 2'd3
    } task_state_t;

    localparam logic [16:0] TICK_WRAP = 17'd65000;

    typedef struct packed {
        op_t         op;
        logic [15:0] task_handle;
        logic [7:0]  task_priority;
        logic [15:0] task_period;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        chosen_valid;
        logic [15:0] chosen_handle;
        logic [2:0]  chosen_slot;
    } rsp_t;

endpackage

// File: sv/priority_periodic_task_scheduler.sv
// Priority periodic task scheduler: task table in one synchronous memory,
// walked slot by slot by a sequencer with a shared serial modulo unit.
// Depends on ppts_pkg.
//
// Usage:
//   Requests enter on req (req_valid/req_stall); each one produces exactly one
//   response on rsp (rsp_valid/rsp_stall). Ops: create, delete, tick, schedule.
//   Tick and null-handle requests go straight to the DONE step. Create and
//   delete walk the table until the first hit. A schedule pass visits every
//   slot and runs the bit-serial modulo for each waiting slot with a nonzero
//   period. That modulo (one quotient bit per cycle) sets the worst case.
//   One request is in work at a time. The next request is taken as soon as
//   the sequencer is idle, while the previous response may still wait in the
//   output register.
//   If the receiver stalls, the response holds in the output register and a
//   finished request waits in the DONE step until the register frees.
//   Reset: all slots read as free (per-slot valid bits clear), tick count is 1,
//   no response pending. No clearing pass is needed.
module priority_periodic_task_scheduler #(
    parameter int TASK_SLOTS   = 8,
    parameter int MAX_PRIORITY = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ppts_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ppts_pkg::rsp_t rsp
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int PW = $clog2(MAX_PRIORITY + 1);
    localparam int EW = 16 + PW + 16 + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_WIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } seq_t;

    // Task table: {handle, priority, period, state} per slot.
    logic [EW-1:0]         mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] vld_reg;
    logic [EW-1:0]         rdata_reg;
    logic                  rvld_reg;

    seq_t               state_reg, state_next;
    ppts_pkg::req_t     req_reg;
    logic [SW-1:0]      idx_reg;
    logic [15:0]        tick_reg;
    ppts_pkg::status_t  status_reg, status_next;

    logic [15:0]        cur_handle_reg;
    logic [PW-1:0]      cur_prio_reg;
    logic [15:0]        cur_period_reg;
    ppts_pkg::task_state_t cur_st_reg;
    ppts_pkg::task_state_t st1_reg;
    logic               rel_reg;

    logic [15:0]        rem_reg;
    logic [15:0]        dvd_reg;
    logic [3:0]         dcnt_reg;

    logic               best_found_reg;
    logic [PW-1:0]      best_prio_reg;
    logic [SW-1:0]      best_idx_reg;
    logic [15:0]        best_handle_reg;
    logic [EW-1:0]      best_word_reg;

    ppts_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg;

    // Current read entry; an unwritten slot reads as free and dormant.
    logic [EW-1:0]      ent;
    logic [15:0]        e_handle;
    logic [PW-1:0]      e_prio;
    logic [15:0]        e_period;
    ppts_pkg::task_state_t e_st, e_st1;

    logic               last;
    logic [PW-1:0]      req_prio_clamped;
    logic               req_clamp;
    logic [16:0]        tick_inc;
    logic [16:0]        div_t;
    logic               div_ge;
    ppts_pkg::task_state_t st2;
    logic               take_best;

    logic               we;
    logic [SW-1:0]      wa;
    logic [EW-1:0]      wd;

    assign ent      = rvld_reg ? rdata_reg : '0;
    assign e_handle = ent[EW-1 -: 16];
    assign e_prio   = ent[EW-17 -: PW];
    assign e_period = ent[17:2];
    assign e_st     = ppts_pkg::task_state_t'(ent[1:0]);
    assign e_st1    = (e_st == ppts_pkg::TS_RUNNING) ? ppts_pkg::TS_WAITING : e_st;

    assign last      = (idx_reg == SW'(TASK_SLOTS - 1));
    assign req_clamp = (req_reg.task_priority > 8'(MAX_PRIORITY));
    assign req_prio_clamped = req_clamp ? PW'(MAX_PRIORITY) : PW'(req_reg.task_priority);

    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign div_t    = {rem_reg, dvd_reg[15]};
    assign div_ge   = (div_t >= {1'b0, cur_period_reg});

    assign st2       = rel_reg ? ppts_pkg::TS_READY : st1_reg;
    assign take_best = (st2 == ppts_pkg::TS_READY) && (cur_prio_reg > best_prio_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer: walk the table one slot at a time.
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ppts_pkg::ST_OK;
                    if (req.op == ppts_pkg::OP_TICK)
                        state_next = S_DONE;
                    else if ((req.op == ppts_pkg::OP_CREATE || req.op == ppts_pkg::OP_DELETE)
                             && req.task_handle == 16'd0)
                    begin
                        status_next = ppts_pkg::ST_NULL;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_RD;
                end
            end
            S_RD:   state_next = S_EVAL;
            S_EVAL:
            begin
                unique case (req_reg.op)
                    ppts_pkg::OP_CREATE:
                    begin
                        if (e_handle == 16'd0)
                        begin
                            status_next = req_clamp ? ppts_pkg::ST_CLAMPED : ppts_pkg::ST_OK;
                            state_next  = S_DONE;
                        end
                        else if (last)
                        begin
                            status_next = ppts_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                            state_next = S_RD;
                    end
                    ppts_pkg::OP_DELETE:
                    begin
                        if (e_handle == req_reg.task_handle)
                            state_next = S_DONE;
                        else if (last)
                        begin
                            status_next = ppts_pkg::ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                        else
                            state_next = S_RD;
                    end
                    default:
                    begin
                        if (e_st1 == ppts_pkg::TS_WAITING && e_period != 16'd0)
                            state_next = S_DIV;
                        else
                            state_next = S_UPD;
                    end
                endcase
            end
            S_DIV:  if (dcnt_reg == 4'd15) state_next = S_UPD;
            S_UPD:  state_next = last ? S_WIN : S_RD;
            S_WIN:  state_next = S_DONE;
            S_DONE: if (!rsp_valid_reg || !rsp_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Single write port into the table.
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = '0;
        if (state_reg == S_EVAL && req_reg.op == ppts_pkg::OP_CREATE && e_handle == 16'd0)
        begin
            we = 1'b1;
            wd = {req_reg.task_handle, req_prio_clamped, req_reg.task_period,
                  ppts_pkg::TS_READY};
        end
        else if (state_reg == S_EVAL && req_reg.op == ppts_pkg::OP_DELETE
                 && e_handle == req_reg.task_handle)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_UPD && st2 != cur_st_reg)
        begin
            we = 1'b1;
            wd = {cur_handle_reg, cur_prio_reg, cur_period_reg, st2};
        end
        else if (state_reg == S_WIN && best_found_reg)
        begin
            we = 1'b1;
            wa = best_idx_reg;
            wd = best_word_reg;
        end
    end

    // Memory array: write, and registered read of the addressed slot.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (state_reg == S_RD)
            rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[wa] <= 1'b1;
            if (state_reg == S_RD)
                rvld_reg <= vld_reg[idx_reg];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= 16'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && req_valid && req.op == ppts_pkg::OP_TICK)
                tick_reg <= (tick_inc >= ppts_pkg::TICK_WRAP) ? 16'd1 : tick_inc[15:0];
            if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg        <= req;
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
                best_prio_reg  <= '0;
            end
            S_EVAL:
            begin
                cur_handle_reg <= e_handle;
                cur_prio_reg   <= e_prio;
                cur_period_reg <= e_period;
                cur_st_reg     <= e_st;
                st1_reg        <= e_st1;
                rel_reg        <= 1'b0;
                rem_reg        <= '0;
                dvd_reg        <= tick_reg;
                dcnt_reg       <= '0;
                if (req_reg.op != ppts_pkg::OP_SCHEDULE && !last)
                    idx_reg <= idx_reg + SW'(1);
            end
            S_DIV:
            begin
                // Restoring remainder: one dividend bit per cycle.
                rem_reg  <= div_ge ? 16'(div_t - {1'b0, cur_period_reg}) : div_t[15:0];
                dvd_reg  <= {dvd_reg[14:0], 1'b0};
                dcnt_reg <= dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd15)
                    rel_reg <= div_ge ? (16'(div_t - {1'b0, cur_period_reg}) == 16'd0)
                                      : (div_t[15:0] == 16'd0);
            end
            S_UPD:
            begin
                if (take_best)
                begin
                    best_found_reg  <= 1'b1;
                    best_prio_reg   <= cur_prio_reg;
                    best_idx_reg    <= idx_reg;
                    best_handle_reg <= cur_handle_reg;
                    best_word_reg   <= {cur_handle_reg, cur_prio_reg, cur_period_reg,
                                        ppts_pkg::TS_RUNNING};
                end
                if (!last)
                    idx_reg <= idx_reg + SW'(1);
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_reg.status <= status_reg;
                    if (req_reg.op == ppts_pkg::OP_SCHEDULE && best_found_reg)
                    begin
                        rsp_reg.chosen_valid  <= 1'b1;
                        rsp_reg.chosen_handle <= best_handle_reg;
                        rsp_reg.chosen_slot   <= 3'(best_idx_reg);
                    end
                    else
                    begin
                        rsp_reg.chosen_valid  <= 1'b0;
                        rsp_reg.chosen_handle <= 16'd0;
                        rsp_reg.chosen_slot   <= 3'd0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/ppts_checker.sv
// Port-level checker for the priority periodic task scheduler, bound to the top.
// Depends on ppts_pkg.
module ppts_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ppts_pkg::rsp_t rsp
);

    // Hold a stalled response.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A chosen task always comes with an ok status.
    a_chosen_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.chosen_valid |-> rsp.status == ppts_pkg::ST_OK)
        else $error("chosen task with non-ok status");

    // No choice: handle and slot read zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.chosen_valid |-> rsp.chosen_handle == 16'd0 && rsp.chosen_slot == 3'd0)
        else $error("idle choice fields not zero");

    // A live task never has the null handle.
    a_chosen_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.chosen_valid |-> rsp.chosen_handle != 16'd0)
        else $error("null handle chosen");

    // A request taken while idle puts the sequencer to work next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted without going busy");

endmodule

bind priority_periodic_task_scheduler ppts_checker u_ppts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: tb/testbench.sv
// Self-checking testbench for the priority periodic task scheduler.
// Drives create/delete/tick/schedule requests and checks every response
// against a built-in task-table model. Depends on ppts_pkg and the block.
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS   = 8;
    localparam int PRIO_MAX = 15;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ppts_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ppts_pkg::rsp_t rsp;

    priority_periodic_task_scheduler #(
        .TASK_SLOTS  (SLOTS),
        .MAX_PRIORITY(PRIO_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // Shadow task table, updated as each request is accepted.
    logic [15:0]            tbl_handle [SLOTS];
    logic [3:0]             tbl_prio   [SLOTS];
    logic [15:0]            tbl_period [SLOTS];
    ppts_pkg::task_state_t  tbl_state  [SLOTS];
    logic [15:0]            tick_now;

    ppts_pkg::req_t pending_reqs[$];
    ppts_pkg::rsp_t expected_rsps[$];

    int  error_count;
    int  accepted_reqs;
    int  checked_rsps;
    int  picks_seen;
    int  idle_cycles;
    bit  stimulus_done;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Compute the response of one request and update the shadow table.
    function automatic ppts_pkg::rsp_t schedule_model(ppts_pkg::req_t r);
        ppts_pkg::rsp_t o;
        int   best;
        logic [3:0] best_prio;
        bit   hit;
        o = '0;
        o.status = ppts_pkg::ST_OK;
        case (r.op)
            ppts_pkg::OP_CREATE:
            begin
                hit = 0;
                if (r.task_handle == 16'd0)
                    o.status = ppts_pkg::ST_NULL;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && tbl_handle[i] == 16'd0)
                        begin
                            hit = 1;
                            tbl_handle[i] = r.task_handle;
                            tbl_period[i] = r.task_period;
                            tbl_state[i]  = ppts_pkg::TS_READY;
                            if (r.task_priority > 8'(PRIO_MAX))
                            begin
                                tbl_prio[i] = 4'(PRIO_MAX);
                                o.status = ppts_pkg::ST_CLAMPED;
                            end
                            else
                                tbl_prio[i] = r.task_priority[3:0];
                        end
                    end
                    if (!hit)
                        o.status = ppts_pkg::ST_FULL;
                end
            end
            ppts_pkg::OP_DELETE:
            begin
                hit = 0;
                if (r.task_handle == 16'd0)
                    o.status = ppts_pkg::ST_NULL;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && tbl_handle[i] == r.task_handle)
                        begin
                            hit = 1;
                            tbl_handle[i] = 16'd0;
                            tbl_period[i] = 16'd0;
                            tbl_prio[i]   = 4'd0;
                            tbl_state[i]  = ppts_pkg::TS_DORMANT;
                        end
                    end
                    if (!hit)
                        o.status = ppts_pkg::ST_NOT_FOUND;
                end
            end
            ppts_pkg::OP_TICK:
                // Wrap from 64999 back to 1; the counter never shows 65000.
                tick_now = (17'(tick_now) + 17'd1 >= ppts_pkg::TICK_WRAP) ? 16'd1
                                                                          : tick_now + 16'd1;
            default:
            begin
                best = -1;
                best_prio = 4'd0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_state[i] == ppts_pkg::TS_RUNNING)
                        tbl_state[i] = ppts_pkg::TS_WAITING;
                    // A task demoted above can be released in the same pass.
                    if (tbl_state[i] == ppts_pkg::TS_WAITING && tbl_period[i] != 16'd0
                        && tick_now % tbl_period[i] == 16'd0)
                        tbl_state[i] = ppts_pkg::TS_READY;
                    if (tbl_state[i] == ppts_pkg::TS_READY && tbl_prio[i] > best_prio)
                    begin
                        best_prio = tbl_prio[i];
                        best = i;
                    end
                end
                if (best >= 0)
                begin
                    tbl_state[best] = ppts_pkg::TS_RUNNING;
                    o.chosen_valid  = 1'b1;
                    o.chosen_handle = tbl_handle[best];
                    o.chosen_slot   = 3'(best);
                end
            end
        endcase
        return o;
    endfunction

    function automatic ppts_pkg::req_t make_req(ppts_pkg::op_t op, logic [15:0] h,
                                                logic [7:0] p, logic [15:0] per);
        ppts_pkg::req_t r;
        r.op = op;
        r.task_handle = h;
        r.task_priority = p;
        r.task_period = per;
        return r;
    endfunction

    // Driver: hold each request until accepted; the gaps between requests are drawn at random.
    int req_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(schedule_model(req));
                accepted_reqs++;
            end
            if (req_valid && req_stall)
            begin
                // hold the stalled request unchanged
            end
            else if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap   <= req_gap - 1;
            end
            else if (pending_reqs.size() > 0 && !(req_valid && !req_stall && $urandom_range(0, 1)))
            begin
                req_valid <= 1'b1;
                req       <= pending_reqs.pop_front();
                // Draw the gap that follows this request; bursts come from 0.
                req_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
            else
            begin
                req_valid <= 1'b0;
                if (req_valid && !req_stall)
                    req_gap <= $urandom_range(0, 5);
            end
        end
    end

    // Monitor: stall at random, compare each accepted response in order.
    int   stall_left;
    ppts_pkg::rsp_t exp_rsp;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no request outstanding: %p", rsp);
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    checked_rsps++;
                    if (exp_rsp.chosen_valid)
                        picks_seen++;
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.chosen_valid !== exp_rsp.chosen_valid)
                    begin
                        $error("chosen_valid: expected %0d, got %0d",
                               exp_rsp.chosen_valid, rsp.chosen_valid);
                        error_count++;
                    end
                    if (rsp.chosen_handle !== exp_rsp.chosen_handle)
                    begin
                        $error("chosen_handle: expected %0h, got %0h",
                               exp_rsp.chosen_handle, rsp.chosen_handle);
                        error_count++;
                    end
                    if (rsp.chosen_slot !== exp_rsp.chosen_slot)
                    begin
                        $error("chosen_slot: expected %0d, got %0d",
                               exp_rsp.chosen_slot, rsp.chosen_slot);
                        error_count++;
                    end
                end
                stall_left <= $urandom_range(0, 5);
                rsp_stall  <= 1'b0;
            end
            else if (stall_left > 0 && $urandom_range(0, 3) != 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired: %0d requests pending, %0d responses outstanding",
                     pending_reqs.size(), expected_rsps.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Draw a handle, mostly from a small pool so deletes and duplicates hit.
    function automatic logic [15:0] pick_handle();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [7:0] pick_prio();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom);
            1:       return 8'd0;
            default: return 8'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic queue_random(int count);
        int  roll;
        ppts_pkg::op_t op;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                op = ppts_pkg::OP_CREATE;
            else if (roll < 40)
                op = ppts_pkg::OP_DELETE;
            else if (roll < 65)
                op = ppts_pkg::OP_TICK;
            else
                op = ppts_pkg::OP_SCHEDULE;
            // Noise in unused fields of tick and schedule requests.
            if (op == ppts_pkg::OP_TICK || op == ppts_pkg::OP_SCHEDULE)
                pending_reqs.push_back(make_req(op, 16'($urandom), 8'($urandom),
                                                16'($urandom)));
            else
                pending_reqs.push_back(make_req(op, pick_handle(), pick_prio(),
                                                pick_period()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        picks_seen = 0;
        stimulus_done = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_handle[i] = 16'd0;
            tbl_prio[i]   = 4'd0;
            tbl_period[i] = 16'd0;
            tbl_state[i]  = ppts_pkg::TS_DORMANT;
        end
        tick_now = 16'd1;

        // Directed: empty schedule, null handles, clamp, full table, miss,
        // zero priority, zero period, ties and same-pass release.
        pending_reqs.push_back(make_req(ppts_pkg::OP_SCHEDULE, 16'hFFFF, 8'hFF, 16'hFFFF));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd0, 8'd5, 16'd1));
        pending_reqs.push_back(make_req(ppts_pkg::OP_DELETE, 16'd0, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_DELETE, 16'd77, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'hFFFF, 8'hFF, 16'hFFFF));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd1, 8'd0, 16'd1));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd2, 8'd15, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd3, 8'd16, 16'd2));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd3, 8'd9, 16'd1));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd5, 8'd9, 16'd3));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd6, 8'd1, 16'd1));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd7, 8'd2, 16'd4));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd8, 8'd3, 16'd1));
        pending_reqs.push_back(make_req(ppts_pkg::OP_CREATE, 16'd9, 8'd3, 16'd1));
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(make_req(ppts_pkg::OP_SCHEDULE, 16'd0, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_TICK, 16'd0, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_SCHEDULE, 16'd0, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_DELETE, 16'd3, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_DELETE, 16'hFFFF, 8'd0, 16'd0));
        pending_reqs.push_back(make_req(ppts_pkg::OP_SCHEDULE, 16'd0, 8'd0, 16'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_random(1630);

        wait (pending_reqs.size() == 0 && !req_valid);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge clk);

        $display("covered %0d requests, %0d responses checked, %0d tasks dispatched",
                 accepted_reqs, checked_rsps, picks_seen);
        $display("tick counter ended at %0d", tick_now);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
